FILE: rtl/spvt_pkg.sv
`default_nettype none

package spvt_pkg;

  // angle quantization of the sine table
  localparam int TRIG_TABLE_BITS = 10;
  localparam int QUARTER_STEPS   = 2 ** (TRIG_TABLE_BITS - 2);
  localparam int KIDX_W          = TRIG_TABLE_BITS - 2;
  localparam int QIDX_W          = TRIG_TABLE_BITS - 1;

  // Q2.62 constants for the table build
  localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;
  localparam logic [63:0] ONE_Q62     = 64'h4000000000000000;
  localparam int          TAYLOR_TERMS = 13;

  // one in Q16.16 for the trig values
  localparam logic signed [17:0] TRIG_ONE = 18'sd65536;

  // register reset values
  localparam logic [31:0] SCALE_RESET  = 32'h0001_0000;
  localparam logic [31:0] RESIZE_RESET = 32'h1000_1000;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_POSITION_X = 3'd0,
    REG_POSITION_Y = 3'd1,
    REG_PIVOT_X    = 3'd2,
    REG_PIVOT_Y    = 3'd3,
    REG_SCALE_X    = 3'd4,
    REG_SCALE_Y    = 3'd5,
    REG_ANGLE      = 3'd6,
    REG_RESIZE     = 3'd7
  } cfg_idx_t;

  // one vertex moving through the pipeline
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic               last;
  } vert_t;

  // settings used by the resize / pivot / scale part
  typedef struct packed {
    logic        [31:0] resize;
    logic signed [31:0] pivot_x;
    logic signed [31:0] pivot_y;
    logic signed [31:0] scale_x;
    logic signed [31:0] scale_y;
  } front_cfg_t;

  // settings used by the rotate / translate part
  typedef struct packed {
    logic signed [17:0] cos_v;
    logic signed [17:0] sin_v;
    logic signed [31:0] pivot_x;
    logic signed [31:0] pivot_y;
    logic signed [31:0] position_x;
    logic signed [31:0] position_y;
  } rot_cfg_t;

  typedef logic [16:0] sine_rom_t [QUARTER_STEPS + 1];

  // clamp to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] res;
    if (v > 64'sd2147483647) begin
      res = 32'sh7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      res = 32'sh8000_0000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

  // (a * b) >> 62 in Q2.62
  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // restoring long division, only evaluated while the table is built
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // quarter-wave sine table, Taylor series in Q2.62, rounded to Q16.16
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t   rom;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] kk;
    logic [63:0] div;
    logic [63:0] rnd;
    for (int k = 0; k <= QUARTER_STEPS; k++) begin
      kk   = 64'(k) << (64 - TRIG_TABLE_BITS);
      x    = mul_q62(HALF_PI_Q62, kk);
      x2   = mul_q62(x, x);
      term = x;
      sum  = x;
      for (int n = 1; n <= TAYLOR_TERMS; n++) begin
        div  = 64'((2 * n) * (2 * n + 1));
        term = udiv64(mul_q62(term, x2), div);
        if ((n & 1) == 1) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      if (sum > ONE_Q62) begin
        sum = ONE_Q62;
      end
      rnd    = sum + (64'd1 << 45);
      rom[k] = rnd[62:46];
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

`default_nettype wire

FILE: rtl/sprite_polygon_vertex_transform.sv
// Polygon vertex transform: resize, pivot, scale, rotate, translate.
// Input channel in_*: one vertex per item, x and y signed Q16.16 in
// in_tdata, in_tlast marks the final vertex of a polygon.
// Output channel out_*: the transformed vertex, saturated, with out_tlast
// copied from the input item.
// Configuration: cfg_we writes cfg_wdata into register cfg_addr at the
// clock edge; registers are position x/y, pivot x/y, scale x/y, angle and
// the packed resize pair. Write only while no item is in flight.
// Pipeline: seven register stages (four stages for resize, pivot and
// scale, three for rotation and translation).
// Throughput: one item per cycle while the receiver accepts every item;
// each stage holds one 32x32 or smaller multiply or one add-and-clamp.
// Sine and cosine are looked up from the angle register into a register
// of their own, updated in the cycle after a write.
// Reset (rst_n low, synchronous): registers take their reset values
// (identity transform) and the pipeline empties.
// Receiver stall: stages hold their items, empty stages keep filling, and
// in_tready drops only once all seven stages are full.
`default_nettype none

module sprite_polygon_vertex_transform (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [63:0] in_tdata,   // vert_x [31:0], vert_y [63:32]
  input  wire logic        in_tlast,
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [63:0] out_tdata,  // out_x [31:0], out_y [63:32]
  output      logic        out_tlast,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [31:0] cfg_wdata
);

  logic signed [31:0] position_x_r;
  logic signed [31:0] position_y_r;
  logic signed [31:0] pivot_x_r;
  logic signed [31:0] pivot_y_r;
  logic signed [31:0] scale_x_r;
  logic signed [31:0] scale_y_r;
  logic        [15:0] angle_r;
  logic        [31:0] resize_r;

  logic signed [17:0] cos_r;
  logic signed [17:0] sin_r;

  spvt_pkg::vert_t      in_vert;
  spvt_pkg::vert_t      mid_vert;
  spvt_pkg::vert_t      out_vert;
  spvt_pkg::front_cfg_t front_cfg;
  spvt_pkg::rot_cfg_t   rot_cfg;
  logic                 mid_valid;
  logic                 mid_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      position_x_r <= '0;
      position_y_r <= '0;
      pivot_x_r    <= '0;
      pivot_y_r    <= '0;
      scale_x_r    <= spvt_pkg::SCALE_RESET;
      scale_y_r    <= spvt_pkg::SCALE_RESET;
      angle_r      <= '0;
      resize_r     <= spvt_pkg::RESIZE_RESET;
    end else if (cfg_we) begin
      unique case (spvt_pkg::cfg_idx_t'(cfg_addr))
        spvt_pkg::REG_POSITION_X: position_x_r <= cfg_wdata;
        spvt_pkg::REG_POSITION_Y: position_y_r <= cfg_wdata;
        spvt_pkg::REG_PIVOT_X:    pivot_x_r    <= cfg_wdata;
        spvt_pkg::REG_PIVOT_Y:    pivot_y_r    <= cfg_wdata;
        spvt_pkg::REG_SCALE_X:    scale_x_r    <= cfg_wdata;
        spvt_pkg::REG_SCALE_Y:    scale_y_r    <= cfg_wdata;
        spvt_pkg::REG_ANGLE:      angle_r      <= cfg_wdata[15:0];
        default:                  resize_r     <= cfg_wdata;
      endcase
    end
  end

  // sine and cosine of the current angle
  spvt_trig u_trig (
    .clk   (clk),
    .rst_n (rst_n),
    .angle (angle_r),
    .cos_r (cos_r),
    .sin_r (sin_r)
  );

  assign in_vert.x    = in_tdata[31:0];
  assign in_vert.y    = in_tdata[63:32];
  assign in_vert.last = in_tlast;

  assign front_cfg.resize  = resize_r;
  assign front_cfg.pivot_x = pivot_x_r;
  assign front_cfg.pivot_y = pivot_y_r;
  assign front_cfg.scale_x = scale_x_r;
  assign front_cfg.scale_y = scale_y_r;

  assign rot_cfg.cos_v      = cos_r;
  assign rot_cfg.sin_v      = sin_r;
  assign rot_cfg.pivot_x    = pivot_x_r;
  assign rot_cfg.pivot_y    = pivot_y_r;
  assign rot_cfg.position_x = position_x_r;
  assign rot_cfg.position_y = position_y_r;

  // resize, pivot and scale
  spvt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_vert   (in_vert),
    .cfg       (front_cfg),
    .out_valid (mid_valid),
    .out_ready (mid_ready),
    .out_vert  (mid_vert)
  );

  // rotate and translate
  spvt_rotate u_rotate (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (mid_valid),
    .in_ready  (mid_ready),
    .in_vert   (mid_vert),
    .cfg       (rot_cfg),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_vert  (out_vert)
  );

  assign out_tdata = {out_vert.y, out_vert.x};
  assign out_tlast = out_vert.last;

  // the input side only backs up when the whole pipeline is full and stalled
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready && mid_valid && !mid_ready)
    else $error("input stalled while the pipeline had room");

endmodule

`default_nettype wire

FILE: rtl/spvt_trig.sv
`default_nettype none

module spvt_trig (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic        [15:0] angle,
  output      logic signed [17:0] cos_r,
  output      logic signed [17:0] sin_r
);

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_t;

  logic [spvt_pkg::TRIG_TABLE_BITS-1:0] idx;
  logic [spvt_pkg::KIDX_W-1:0]          k;
  logic [spvt_pkg::QIDX_W-1:0]          k_up;
  logic [spvt_pkg::QIDX_W-1:0]          k_dn;
  quad_t                                quad;
  logic signed [17:0]                   tk;
  logic signed [17:0]                   tr;
  logic signed [17:0]                   cos_nxt;
  logic signed [17:0]                   sin_nxt;

  // truncate the angle, split into quadrant and table index
  assign idx  = angle[15 -: spvt_pkg::TRIG_TABLE_BITS];
  assign quad = quad_t'(idx[spvt_pkg::TRIG_TABLE_BITS-1 -: 2]);
  assign k    = idx[spvt_pkg::KIDX_W-1:0];
  assign k_up = {1'b0, k};
  assign k_dn = spvt_pkg::QIDX_W'(spvt_pkg::QUARTER_STEPS) - k_up;
  assign tk   = {1'b0, spvt_pkg::SINE_ROM[k_up]};
  assign tr   = {1'b0, spvt_pkg::SINE_ROM[k_dn]};

  // fold the quarter wave out to the full turn
  always_comb begin
    unique case (quad)
      QUAD_0: begin
        sin_nxt = tk;
        cos_nxt = tr;
      end
      QUAD_1: begin
        sin_nxt = tr;
        cos_nxt = -tk;
      end
      QUAD_2: begin
        sin_nxt = -tk;
        cos_nxt = -tr;
      end
      default: begin
        sin_nxt = -tr;
        cos_nxt = tk;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cos_r <= spvt_pkg::TRIG_ONE;
      sin_r <= '0;
    end else begin
      cos_r <= cos_nxt;
      sin_r <= sin_nxt;
    end
  end

  // zero angle gives the identity rotation
  a_zero_angle: assert property (@(posedge clk) disable iff (!rst_n)
    angle == 16'd0 |=> cos_r == spvt_pkg::TRIG_ONE && sin_r == 18'sd0)
    else $error("zero angle did not give identity rotation");

endmodule

`default_nettype wire

FILE: rtl/spvt_front.sv
`default_nettype none

module spvt_front (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output      logic                  in_ready,
  input  wire spvt_pkg::vert_t       in_vert,
  input  wire spvt_pkg::front_cfg_t  cfg,
  output      logic                  out_valid,
  input  wire logic                  out_ready,
  output      spvt_pkg::vert_t       out_vert
);

  localparam int STAGES = 4;

  logic [STAGES-1:0] v_r;
  logic [STAGES:0]   en;

  logic signed [48:0] p1x;
  logic signed [48:0] p1y;
  logic signed [48:0] p1x_r;
  logic signed [48:0] p1y_r;
  logic               l1_r;

  logic signed [48:0] r2x;
  logic signed [48:0] r2y;
  logic signed [31:0] a2x;
  logic signed [31:0] a2y;
  logic signed [63:0] dfx;
  logic signed [63:0] dfy;
  logic signed [31:0] d2x_r;
  logic signed [31:0] d2y_r;
  logic               l2_r;

  logic signed [63:0] m3x_r;
  logic signed [63:0] m3y_r;
  logic               l3_r;

  logic signed [63:0] r4x;
  logic signed [63:0] r4y;
  logic signed [31:0] s4x_r;
  logic signed [31:0] s4y_r;
  logic               l4_r;

  // a stage moves when it is empty or the next one moves
  always_comb begin
    en[STAGES] = out_ready;
    for (int i = STAGES - 1; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[STAGES-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_valid;
      end
      for (int i = 1; i < STAGES; i++) begin
        if (en[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  // stage 1: vertex times unsigned Q4.12 resize
  assign p1x = $signed({{17{in_vert.x[31]}}, in_vert.x}) * $signed({33'd0, cfg.resize[15:0]});
  assign p1y = $signed({{17{in_vert.y[31]}}, in_vert.y}) * $signed({33'd0, cfg.resize[31:16]});

  // stage 2: round, clamp, subtract pivot, clamp
  assign r2x = (p1x_r + 49'sd2048) >>> 12;
  assign r2y = (p1y_r + 49'sd2048) >>> 12;
  assign a2x = spvt_pkg::sat32({{15{r2x[48]}}, r2x});
  assign a2y = spvt_pkg::sat32({{15{r2y[48]}}, r2y});
  assign dfx = {{32{a2x[31]}}, a2x} - {{32{cfg.pivot_x[31]}}, cfg.pivot_x};
  assign dfy = {{32{a2y[31]}}, a2y} - {{32{cfg.pivot_y[31]}}, cfg.pivot_y};

  // stage 4: round away the scale fraction and clamp
  assign r4x = (m3x_r + 64'sd32768) >>> 16;
  assign r4y = (m3y_r + 64'sd32768) >>> 16;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      p1x_r <= p1x;
      p1y_r <= p1y;
      l1_r  <= in_vert.last;
    end
    if (en[1]) begin
      d2x_r <= spvt_pkg::sat32(dfx);
      d2y_r <= spvt_pkg::sat32(dfy);
      l2_r  <= l1_r;
    end
    // stage 3: per-axis scale
    if (en[2]) begin
      m3x_r <= d2x_r * cfg.scale_x;
      m3y_r <= d2y_r * cfg.scale_y;
      l3_r  <= l2_r;
    end
    if (en[3]) begin
      s4x_r <= spvt_pkg::sat32(r4x);
      s4y_r <= spvt_pkg::sat32(r4y);
      l4_r  <= l3_r;
    end
  end

  assign out_vert.x    = s4x_r;
  assign out_vert.y    = s4y_r;
  assign out_vert.last = l4_r;

endmodule

`default_nettype wire

FILE: rtl/spvt_rotate.sv
`default_nettype none

module spvt_rotate (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output      logic                in_ready,
  input  wire spvt_pkg::vert_t     in_vert,
  input  wire spvt_pkg::rot_cfg_t  cfg,
  output      logic                out_valid,
  input  wire logic                out_ready,
  output      spvt_pkg::vert_t     out_vert
);

  localparam int STAGES = 3;

  logic [STAGES-1:0] v_r;
  logic [STAGES:0]   en;

  logic signed [49:0] pcx_r;
  logic signed [49:0] psy_r;
  logic signed [49:0] psx_r;
  logic signed [49:0] pcy_r;
  logic               l1_r;

  logic signed [50:0] sum_x;
  logic signed [50:0] sum_y;
  logic signed [50:0] r2x;
  logic signed [50:0] r2y;
  logic signed [31:0] rx_r;
  logic signed [31:0] ry_r;
  logic               l2_r;

  logic signed [33:0] wx;
  logic signed [33:0] wy;
  logic signed [31:0] ox_r;
  logic signed [31:0] oy_r;
  logic               l3_r;

  // a stage moves when it is empty or the next one moves
  always_comb begin
    en[STAGES] = out_ready;
    for (int i = STAGES - 1; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[STAGES-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_valid;
      end
      for (int i = 1; i < STAGES; i++) begin
        if (en[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  // stage 2: combine the rotation products, round and clamp
  assign sum_x = {pcx_r[49], pcx_r} - {psy_r[49], psy_r};
  assign sum_y = {psx_r[49], psx_r} + {pcy_r[49], pcy_r};
  assign r2x   = (sum_x + 51'sd32768) >>> 16;
  assign r2y   = (sum_y + 51'sd32768) >>> 16;

  // stage 3: add position and pivot back in one sum
  assign wx = {{2{cfg.position_x[31]}}, cfg.position_x} + {{2{rx_r[31]}}, rx_r}
            + {{2{cfg.pivot_x[31]}}, cfg.pivot_x};
  assign wy = {{2{cfg.position_y[31]}}, cfg.position_y} + {{2{ry_r[31]}}, ry_r}
            + {{2{cfg.pivot_y[31]}}, cfg.pivot_y};

  always_ff @(posedge clk) begin
    // stage 1: four rotation products
    if (en[0]) begin
      pcx_r <= cfg.cos_v * in_vert.x;
      psy_r <= cfg.sin_v * in_vert.y;
      psx_r <= cfg.sin_v * in_vert.x;
      pcy_r <= cfg.cos_v * in_vert.y;
      l1_r  <= in_vert.last;
    end
    if (en[1]) begin
      rx_r <= spvt_pkg::sat32({{13{r2x[50]}}, r2x});
      ry_r <= spvt_pkg::sat32({{13{r2y[50]}}, r2y});
      l2_r <= l1_r;
    end
    if (en[2]) begin
      ox_r <= spvt_pkg::sat32({{30{wx[33]}}, wx});
      oy_r <= spvt_pkg::sat32({{30{wy[33]}}, wy});
      l3_r <= l2_r;
    end
  end

  assign out_vert.x    = ox_r;
  assign out_vert.y    = oy_r;
  assign out_vert.last = l3_r;

  // a full product stage that cannot move keeps its item
  a_prod_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[0] && !en[1] |=> v_r[0] && $stable(pcx_r) && $stable(pcy_r) && $stable(l1_r))
    else $error("stalled product stage changed");

  // the rounded sum stage drains into the output when that is free
  a_sum_drain: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[1] && (!v_r[2] || out_ready) |=> v_r[2])
    else $error("sum stage item did not reach the output stage");

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD = 12;
  localparam int ANGLE_BITS = spvt_pkg::TRIG_TABLE_BITS;
  localparam int QSTEPS     = 2 ** (ANGLE_BITS - 2);
  localparam int PIPE_DEPTH = 7;
  localparam int RANDOM_PER_REGIME = 530;
  localparam int HOLD_CYCLES = 300;

  localparam logic [63:0] HALF_PI_Q62 = 64'h6487_ED51_10B4_611A;
  localparam logic [63:0] ONE_Q62     = 64'h4000_0000_0000_0000;
  localparam longint MAX32 = 64'sd2147483647;
  localparam longint MIN32 = -64'sd2147483648;
  localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] NEG_MAX = 32'h8000_0000;

  // one vertex, either side of the block
  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic               last;
  } point_t;

  // register values in index order
  typedef logic [0:7][31:0] reg_set_t;

  // directed item: settings group, vertex, and an expected result where obvious
  typedef struct {
    int          group;
    logic [31:0] x;
    logic [31:0] y;
    logic        last;
    logic        fixed_exp;
    logic [31:0] want_x;
    logic [31:0] want_y;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;   // vert_x [31:0], vert_y [63:32]
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;  // out_x [31:0], out_y [63:32]
  logic        out_tlast;
  logic        cfg_we;
  logic [2:0]  cfg_addr;
  logic [31:0] cfg_wdata;

  sprite_polygon_vertex_transform i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #(CLK_PERIOD / 2) clk = 1'b1;
    #(CLK_PERIOD / 2) clk = 1'b0;
  end

  // register groups for the directed part; group 0 is the reset state
  reg_set_t setting_groups [5] = '{
    {32'h0, 32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000, 32'h0, 32'h1000_1000},
    // quarter turn around an offset pivot, moved
    {32'h0064_0000, 32'hFFCE_0000, 32'h000A_0000, 32'hFFFB_0000,
     32'h0001_0000, 32'h0001_0000, 32'h0000_4000, 32'h1000_1000},
    // x resize zero, y doubled, extreme scales, angle with junk above bit 15
    {32'h0, 32'h0, 32'h0003_0000, 32'h0000_8000,
     NEG_MAX, POS_MAX, 32'hABCD_FFFF, 32'h2000_0000},
    // everything at the extremes, half turn
    {POS_MAX, NEG_MAX, NEG_MAX, POS_MAX, POS_MAX, NEG_MAX, 32'h0000_8000, 32'hFFFF_FFFF},
    // eighth turn, fractional scale and resize
    {32'h0001_8000, 32'hFFFF_0000, 32'h0000_0001, 32'hFFFF_FFFF,
     32'h0000_8000, 32'h0003_0000, 32'h0000_2000, 32'h0800_1800}
  };

  localparam int N_DIRECTED = 23;
  stim_row_t stim_table [N_DIRECTED] = '{
    // identity transform: the vertex comes back unchanged
    '{0, 32'h0, 32'h0, 1'b0, 1'b1, 32'h0, 32'h0},
    '{0, POS_MAX, POS_MAX, 1'b0, 1'b1, POS_MAX, POS_MAX},
    '{0, NEG_MAX, NEG_MAX, 1'b0, 1'b1, NEG_MAX, NEG_MAX},
    '{0, POS_MAX, NEG_MAX, 1'b1, 1'b1, POS_MAX, NEG_MAX},
    '{0, NEG_MAX, POS_MAX, 1'b0, 1'b1, NEG_MAX, POS_MAX},
    '{0, 32'h0000_0001, 32'hFFFF_FFFF, 1'b0, 1'b1, 32'h0000_0001, 32'hFFFF_FFFF},
    '{0, 32'h0001_0000, 32'hFFFF_0000, 1'b1, 1'b1, 32'h0001_0000, 32'hFFFF_0000},
    '{0, 32'h1234_5678, 32'hEDCB_A987, 1'b1, 1'b1, 32'h1234_5678, 32'hEDCB_A987},
    '{1, 32'h0, 32'h0, 1'b0, 1'b0, 32'h0, 32'h0},
    '{1, 32'h0001_0000, 32'h0, 1'b0, 1'b0, 32'h0, 32'h0},
    '{1, 32'h0, 32'h0001_0000, 1'b1, 1'b0, 32'h0, 32'h0},
    '{1, NEG_MAX, POS_MAX, 1'b1, 1'b0, 32'h0, 32'h0},
    '{2, 32'h0005_0000, 32'h0002_0000, 1'b0, 1'b0, 32'h0, 32'h0},
    '{2, POS_MAX, 32'hFFFF_8000, 1'b0, 1'b0, 32'h0, 32'h0},
    '{2, NEG_MAX, NEG_MAX, 1'b0, 1'b0, 32'h0, 32'h0},
    '{2, 32'h0000_0001, 32'h0000_0001, 1'b1, 1'b0, 32'h0, 32'h0},
    '{3, 32'h0, 32'h0, 1'b0, 1'b0, 32'h0, 32'h0},
    '{3, POS_MAX, POS_MAX, 1'b0, 1'b0, 32'h0, 32'h0},
    '{3, NEG_MAX, 32'h0001_0000, 1'b0, 1'b0, 32'h0, 32'h0},
    '{3, 32'hFFFF_FFFF, NEG_MAX, 1'b1, 1'b0, 32'h0, 32'h0},
    '{4, 32'h0010_0000, 32'h0, 1'b0, 1'b0, 32'h0, 32'h0},
    '{4, 32'hFFF0_0000, 32'h000C_8000, 1'b0, 1'b0, 32'h0, 32'h0},
    '{4, 32'h0000_7FFF, 32'hFFFF_8001, 1'b1, 1'b0, 32'h0, 32'h0}
  };

  // shadow of the block's registers and its sine table
  logic [31:0] shadow_regs [8];
  longint      sine_q16 [QSTEPS + 1];

  point_t pending_points [$];
  int     error_count = 0;
  int     results_checked = 0;
  int     vertices_sent = 0;
  int     polygons_sent = 0;
  int     settings_applied = 0;
  int     src_idle_pct = 32;
  int     rcv_idle_pct = 69;
  int     hold_request = 0;

  // (a * b) >> 62 on unsigned Q2.62
  function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // quarter-wave sine entry by Taylor series, rounded to Q16.16
  function automatic longint sine_entry(input int k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] acc;
    x    = q62_mul(HALF_PI_Q62, 64'(k) << (64 - ANGLE_BITS));
    x2   = q62_mul(x, x);
    term = x;
    acc  = x;
    for (int n = 1; n <= 13; n++) begin
      term = q62_mul(term, x2) / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        acc = acc - term;
      end else begin
        acc = acc + term;
      end
    end
    if (acc > ONE_Q62) begin
      acc = ONE_Q62;
    end
    acc = acc + (64'd1 << 45);
    return longint'(acc >> 46);
  endfunction

  function automatic longint clamp32(input longint v);
    if (v > MAX32) begin
      return MAX32;
    end
    if (v < MIN32) begin
      return MIN32;
    end
    return v;
  endfunction

  // floor((p + half) / 2^n)
  function automatic longint round_shr(input longint p, input int n);
    return (p + (longint'(1) <<< (n - 1))) >>> n;
  endfunction

  // full transform of one vertex under the shadow registers
  function automatic point_t transform_vertex(input logic [31:0] vx, input logic [31:0] vy,
                                              input logic last);
    point_t      res;
    longint      ax, ay, dx, dy, sx, sy, rx, ry, c, s, tk, tr;
    longint      px, py, rsx, rsy;
    int unsigned idx, quad, k;
    px  = longint'($signed(shadow_regs[spvt_pkg::REG_PIVOT_X]));
    py  = longint'($signed(shadow_regs[spvt_pkg::REG_PIVOT_Y]));
    rsx = longint'(shadow_regs[spvt_pkg::REG_RESIZE][15:0]);
    rsy = longint'(shadow_regs[spvt_pkg::REG_RESIZE][31:16]);
    // resize, pivot, scale
    ax = clamp32(round_shr(longint'($signed(vx)) * rsx, 12));
    ay = clamp32(round_shr(longint'($signed(vy)) * rsy, 12));
    dx = clamp32(ax - px);
    dy = clamp32(ay - py);
    sx = clamp32(round_shr(dx * longint'($signed(shadow_regs[spvt_pkg::REG_SCALE_X])), 16));
    sy = clamp32(round_shr(dy * longint'($signed(shadow_regs[spvt_pkg::REG_SCALE_Y])), 16));
    // quadrant and table position from the top angle bits
    idx  = int'(shadow_regs[spvt_pkg::REG_ANGLE][15:0]) >> (16 - ANGLE_BITS);
    quad = (idx >> (ANGLE_BITS - 2)) & 3;
    k    = idx & (QSTEPS - 1);
    tk   = sine_q16[k];
    tr   = sine_q16[QSTEPS - k];
    case (quad)
      0: begin s = tk;  c = tr;  end
      1: begin s = tr;  c = -tk; end
      2: begin s = -tk; c = -tr; end
      default: begin s = -tr; c = tk; end
    endcase
    rx = clamp32(round_shr(c * sx - s * sy, 16));
    ry = clamp32(round_shr(s * sx + c * sy, 16));
    res.x    = 32'(clamp32(longint'($signed(shadow_regs[spvt_pkg::REG_POSITION_X])) + rx + px));
    res.y    = 32'(clamp32(longint'($signed(shadow_regs[spvt_pkg::REG_POSITION_Y])) + ry + py));
    res.last = last;
    return res;
  endfunction

  // random Q16.16 value biased to extremes, one, zero and moderate values
  function automatic logic [31:0] pick_q16();
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(0, 6))
      0: return r;
      1: return $urandom_range(0, 1) ? POS_MAX : NEG_MAX;
      2: return 32'h0001_0000;
      3: return 32'h0;
      default: return {{10{r[21]}}, r[21:0]};
    endcase
  endfunction

  function automatic logic [15:0] pick_resize();
    case ($urandom_range(0, 5))
      0: return 16'h1000;
      1: return 16'h0000;
      2: return 16'hFFFF;
      3: return 16'($urandom());
      default: return 16'($urandom_range(0, 16'h2000));
    endcase
  endfunction

  function automatic logic [31:0] pick_angle();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return 32'(16384 * $urandom_range(0, 3));
      default: return 32'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [31:0] pick_coord();
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(0, 9))
      0: return r;
      1: return $urandom_range(0, 1) ? POS_MAX : NEG_MAX;
      2: return 32'h0;
      default: return {{8{r[23]}}, r[23:0]};
    endcase
  endfunction

  function automatic reg_set_t random_settings();
    reg_set_t s;
    s[spvt_pkg::REG_POSITION_X] = pick_q16();
    s[spvt_pkg::REG_POSITION_Y] = pick_q16();
    s[spvt_pkg::REG_PIVOT_X]    = pick_q16();
    s[spvt_pkg::REG_PIVOT_Y]    = pick_q16();
    s[spvt_pkg::REG_SCALE_X]    = pick_q16();
    s[spvt_pkg::REG_SCALE_Y]    = pick_q16();
    s[spvt_pkg::REG_ANGLE]      = pick_angle();
    s[spvt_pkg::REG_RESIZE]     = {pick_resize(), pick_resize()};
    return s;
  endfunction

  task automatic write_reg(input spvt_pkg::cfg_idx_t idx, input logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    shadow_regs[idx] = (idx == spvt_pkg::REG_ANGLE) ? {16'd0, value[15:0]} : value;
  endtask

  // only called with the pipeline empty
  task automatic apply_settings(input reg_set_t s);
    for (int i = 0; i < 8; i++) begin
      write_reg(spvt_pkg::cfg_idx_t'(i), s[i]);
    end
    cfg_we <= 1'b0;
    settings_applied++;
  endtask

  // stop offering and wait until every vertex has come back
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_points.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // offer one vertex, with random gaps before it, and record what must come back
  task automatic send_vertex(input logic [31:0] vx, input logic [31:0] vy, input logic last,
                             input logic fixed_exp, input logic [31:0] wx,
                             input logic [31:0] wy);
    point_t want;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {vy, vx};
    in_tlast  <= last;
    do begin
      @(posedge clk);
    end while (!in_tready);
    if (fixed_exp) begin
      want.x    = wx;
      want.y    = wy;
      want.last = last;
    end else begin
      want = transform_vertex(vx, vy, last);
    end
    pending_points.push_back(want);
    vertices_sent++;
    if (last) begin
      polygons_sent++;
    end
  endtask

  task automatic send_polygon(input int count, input logic broken);
    logic last;
    for (int i = 0; i < count; i++) begin
      last = broken ? logic'($urandom_range(0, 1)) : (i == count - 1);
      send_vertex(pick_coord(), pick_coord(), last, 1'b0, 32'h0, 32'h0);
    end
  endtask

  // sine table, same construction as the block's
  initial begin
    for (int k = 0; k <= QSTEPS; k++) begin
      sine_q16[k] = sine_entry(k);
    end
    for (int i = 0; i < 8; i++) begin
      shadow_regs[i] = setting_groups[0][i];
    end
  end

  // result side: random stalls plus one long hold-off
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (!rst_n) begin
        out_tready <= 1'b0;
      end else if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
      end
    end
  end

  // compare each returned vertex with the oldest one waiting
  always @(posedge clk) begin : check_results
    point_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_points.size() == 0) begin
        $error("vertex out with nothing pending: x=%0d y=%0d last=%0b",
               $signed(out_tdata[31:0]), $signed(out_tdata[63:32]), out_tlast);
        error_count++;
      end else begin
        want = pending_points.pop_front();
        results_checked++;
        if (out_tdata[31:0] !== want.x) begin
          $error("out_x mismatch: expected %0d, actual %0d", want.x, $signed(out_tdata[31:0]));
          error_count++;
        end
        if (out_tdata[63:32] !== want.y) begin
          $error("out_y mismatch: expected %0d, actual %0d", want.y, $signed(out_tdata[63:32]));
          error_count++;
        end
        if (out_tlast !== want.last) begin
          $error("out_last mismatch: expected %0b, actual %0b", want.last, out_tlast);
          error_count++;
        end
      end
    end
  end

  // stimulus
  initial begin : stimulus
    int group;
    int regime_count;
    bit hold_done;
    group     = 0;
    hold_done = 1'b0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tlast  <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_addr  <= spvt_pkg::REG_POSITION_X;
    cfg_wdata <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table, first rows under the reset settings
    for (int i = 0; i < N_DIRECTED; i++) begin
      if (stim_table[i].group != group) begin
        drain();
        group = stim_table[i].group;
        apply_settings(setting_groups[group]);
      end
      send_vertex(stim_table[i].x, stim_table[i].y, stim_table[i].last,
                  stim_table[i].fixed_exp, stim_table[i].want_x, stim_table[i].want_y);
    end

    // random polygons in three idling regimes
    for (int regime = 0; regime < 3; regime++) begin
      drain();
      case (regime)
        0: begin src_idle_pct = 32; rcv_idle_pct = 69; end
        1: begin src_idle_pct = 69; rcv_idle_pct = 32; end
        default: begin src_idle_pct = 0; rcv_idle_pct = 0; end
      endcase
      regime_count = vertices_sent;
      while (vertices_sent - regime_count < RANDOM_PER_REGIME) begin
        if ($urandom_range(0, 3) == 0) begin
          drain();
          apply_settings(random_settings());
        end
        if (regime == 2 && !hold_done && vertices_sent - regime_count > 150) begin
          // receiver stops long enough for the pipeline to back up into in_tready
          hold_request = HOLD_CYCLES;
          send_polygon(40, 1'b0);
          hold_done = 1'b1;
        end
        send_polygon($urandom_range(1, 12), $urandom_range(0, 9) == 0);
      end
    end

    drain();
    repeat (PIPE_DEPTH * 3) @(posedge clk);
    if (pending_points.size() != 0) begin
      $error("%0d vertices never came back", pending_points.size());
      error_count++;
    end
    $display("run covered %0d vertices in %0d polygons under %0d register settings",
             vertices_sent, polygons_sent, settings_applied + 1);
    $display("%0d transformed vertices checked, %0d mismatches", results_checked, error_count);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // watchdog
  initial begin : watchdog
    #5_000_000;
    $display("timeout with %0d vertices pending", pending_points.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire
